### hdl/double_ended_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Shorthand for clocked concurrent assertions, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, command and status codes, and the request and response types.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   typedef enum logic [2:0] {
      CMD_PUSH_TOP    = 3'd0,
      CMD_POP_TOP     = 3'd1,
      CMD_APPEND_TAIL = 3'd2,
      CMD_REMOVE_TAIL = 3'd3,
      CMD_NOP         = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef struct packed {
      cmd_type     command;
      logic [31:0] data_in;
   } req_type;

   typedef struct packed {
      logic [31:0] data_out;
      status_type  status;
      logic        not_empty;
   } rsp_type;

   // Shift and write controls broadcast to every cell.
   typedef struct packed {
      logic push;
      logic pop;
      logic append;
      logic remove;
   } ctrl_type;

endpackage

### hdl/deq_cell.sv
// ----------------------------------------------------------------------------
// Double-ended queue cell
// One slot of the queue: a word and an occupied flag, shifted towards or away
// from the top by push and pop, written in place by an append at the tail.
// ----------------------------------------------------------------------------
module deq_cell (
   input  logic               clock,
   input  logic               reset,
   input  deq_pkg::ctrl_type  ctrl,
   input  deq_pkg::word_type  new_word,
   input  deq_pkg::word_type  left_word,
   input  logic               left_valid,
   input  deq_pkg::word_type  right_word,
   input  logic               right_valid,
   output deq_pkg::word_type  word,
   output logic               valid,
   output deq_pkg::word_type  tail_word
);

   deq_pkg::word_type word_ff, word_in;
   logic              valid_ff, valid_in;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      priority if (ctrl.push) begin
         valid_in = left_valid;
         word_in  = left_word;
      end else if (ctrl.pop) begin
         valid_in = right_valid;
         word_in  = right_word;
      end else if (ctrl.append) begin
         // The first free cell behind an occupied one takes the new word.
         valid_in = valid_ff | left_valid;
         if (!valid_ff && left_valid) begin
            word_in = new_word;
         end
      end else if (ctrl.remove) begin
         valid_in = valid_ff & right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign word      = word_ff;
   assign valid     = valid_ff;
   // Only the last occupied cell presents its word towards the tail read.
   assign tail_word = (valid_ff && !right_valid) ? word_ff : '0;

endmodule

### hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of words held in a row of shifting cells, top at cell zero.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; busy
//   stays low, so a request may be issued in every cycle. Each request is
//   one command: push at the top, pop from the top, append at the tail,
//   remove from the tail, or no operation (unused codes behave alike).
//   Exactly one response follows each request, on rsp_payload with
//   rsp_strobe high for one cycle, in the cycle after acceptance. The
//   response carries the removed word (zero when nothing was removed), a
//   status (ok, removal from an empty queue, insert refused when full) and
//   whether the queue holds a word afterwards.
//   Throughput is one request per cycle: each cell updates from its
//   neighbours, and the tail word is found by an OR over the cells'
//   tail outputs.
//   Reset empties the queue at once; no clearing pass is needed. The
//   receiver cannot stall, so a response must be taken in its cycle.
// ----------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module double_ended_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  deq_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output deq_pkg::rsp_type rsp_payload
);

   deq_pkg::word_type              words [deq_pkg::DEPTH];
   deq_pkg::word_type              tail_words [deq_pkg::DEPTH];
   logic [deq_pkg::DEPTH-1:0]      valid_vec;
   deq_pkg::word_type              new_word;
   deq_pkg::word_type              tail_or;
   deq_pkg::ctrl_type              ctrl;
   logic                           accept;
   logic                           full;
   logic                           empty;

   deq_pkg::rsp_type rsp_payload_ff, rsp_payload_in;
   logic             rsp_strobe_ff;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign new_word = deq_pkg::DATA_WIDTH'(req_payload.data_in);
   assign full     = valid_vec[deq_pkg::DEPTH-1];
   assign empty    = !valid_vec[0];

   for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
      deq_pkg::word_type left_word;
      deq_pkg::word_type right_word;
      logic              left_valid;
      logic              right_valid;

      if (i == 0) begin : g_first
         assign left_word  = new_word;
         assign left_valid = 1'b1;
      end else begin : g_inner_left
         assign left_word  = words[i-1];
         assign left_valid = valid_vec[i-1];
      end

      if (i == deq_pkg::DEPTH-1) begin : g_last
         assign right_word  = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner_right
         assign right_word  = words[i+1];
         assign right_valid = valid_vec[i+1];
      end

      deq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_word    (new_word),
         .left_word   (left_word),
         .left_valid  (left_valid),
         .right_word  (right_word),
         .right_valid (right_valid),
         .word        (words[i]),
         .valid       (valid_vec[i]),
         .tail_word   (tail_words[i])
      );
   end

   always_comb begin
      tail_or = '0;
      for (int i = 0; i < deq_pkg::DEPTH; i++) begin
         tail_or = tail_or | tail_words[i];
      end
   end

   always_comb begin
      ctrl                     = '0;
      rsp_payload_in           = '0;
      rsp_payload_in.status    = deq_pkg::STATUS_OK;
      rsp_payload_in.not_empty = !empty;
      unique case (req_payload.command)
         deq_pkg::CMD_PUSH_TOP: begin
            if (full) begin
               rsp_payload_in.status = deq_pkg::STATUS_FULL;
            end else begin
               ctrl.push                = accept;
               rsp_payload_in.not_empty = 1'b1;
            end
         end
         deq_pkg::CMD_APPEND_TAIL: begin
            if (full) begin
               rsp_payload_in.status = deq_pkg::STATUS_FULL;
            end else begin
               ctrl.append              = accept;
               rsp_payload_in.not_empty = 1'b1;
            end
         end
         deq_pkg::CMD_POP_TOP: begin
            if (empty) begin
               rsp_payload_in.status = deq_pkg::STATUS_EMPTY;
            end else begin
               ctrl.pop                 = accept;
               rsp_payload_in.data_out  = 32'(words[0]);
               // A second word means the queue stays occupied.
               rsp_payload_in.not_empty = valid_vec[1];
            end
         end
         deq_pkg::CMD_REMOVE_TAIL: begin
            if (empty) begin
               rsp_payload_in.status = deq_pkg::STATUS_EMPTY;
            end else begin
               ctrl.remove              = accept;
               rsp_payload_in.data_out  = 32'(tail_or);
               rsp_payload_in.not_empty = valid_vec[1];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
      end
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

   `DEQ_ASSERT_NEXT(a_rsp_follows_req, accept, rsp_strobe, "request without response")
   `DEQ_ASSERT_NEXT(a_no_spurious_rsp, !accept, !rsp_strobe, "response without request")
   `DEQ_ASSERT_NOW(a_occupancy_contiguous, 1'b1,
      (valid_vec & (valid_vec + deq_pkg::DEPTH'(1))) == '0,
      "occupied cells not contiguous from the top")
   `DEQ_ASSERT_NOW(a_error_zero_data,
      rsp_strobe && (rsp_payload.status != deq_pkg::STATUS_OK),
      rsp_payload.data_out == 32'd0, "failed request returned data")

endmodule
